// ===== rtl/pjst_pkg.sv =====
// ----------------------------------------------------------------------------
// pjst_pkg: shared types and constants of the periodic job scheduler table
// Holds the mode codes, default sizes and the entry record layout.
// ----------------------------------------------------------------------------
package pjst_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 16;
    localparam int unsigned MAX_WAIT_DEF    = 100;

    localparam logic [1:0] MODE_SCHEDULE = 2'd0;
    localparam logic [1:0] MODE_REMOVE   = 2'd1;
    localparam logic [1:0] MODE_SERVICE  = 2'd2;

    localparam logic [15:0] ID_FIRST = 16'd1;
    localparam logic [15:0] ID_LAST  = 16'hFFFF;

    // one table entry as stored in memory
    typedef struct packed {
        logic [15:0] handle;
        logic [15:0] id;
        logic [31:0] period;
        logic [15:0] runs;
        logic [31:0] stamp;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/periodic_job_scheduler_table.sv =====
// ----------------------------------------------------------------------------
// periodic_job_scheduler_table: ordered table of periodic jobs
// Schedule, remove by id and service operations over a RAM-held table.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one command beat (mode, now, job_handle, period,
//   run_count, target_id). The m_ channel returns exactly one result beat per
//   command, held in an output register until m_ready takes it.
//   One command is worked at a time. The entry RAM is read one address per
//   cycle through its registered read port, so an operation walks the table:
//     schedule writes the new entry as the command is taken; remove and
//     service scan from entry 0 and stop at the hit entry when it stays, or
//     run to the end when nothing hits or when the hit entry leaves (the gap
//     is closed behind the scan); a service that finds nothing rescans.
//   The single read port of the entry RAM sets how long an item takes.
//   s_ready is high only when no command is in work and the result register
//   is empty or being taken. While the receiver stalls the result waits in
//   its register and no new command is taken.
//   Reset empties the table and sets the id counter to 1; RAM contents are
//   left as they are, since only entries below the fill count are read.
// ----------------------------------------------------------------------------
module periodic_job_scheduler_table #(
    parameter int unsigned TABLE_DEPTH = pjst_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned MAX_WAIT    = pjst_pkg::MAX_WAIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [31:0] s_now,
    input  logic [15:0] s_job_handle,
    input  logic [31:0] s_period,
    input  logic signed [15:0] s_run_count,
    input  logic [15:0] s_target_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_op_ok,
    output logic [15:0] m_new_id,
    output logic [15:0] m_due_handle,
    output logic [15:0] m_due_id,
    output logic        m_due_final,
    output logic [6:0]  m_next_wait,
    output logic [4:0]  m_entries_left
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [31:0] MAX_WAIT_W = 32'(MAX_WAIT);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_SHIFT, ST_WAIT_SCAN, ST_DONE
    } state_t;

    state_t state_reg;
    logic [1:0]  mode_reg;
    logic [31:0] now_reg;
    logic [15:0] target_reg;
    logic [CW-1:0] occ_reg;
    logic [15:0] idc_reg;
    logic [CW-1:0] rd_idx_reg;   // read address issued this cycle
    logic          rd_live_reg;  // read data valid this cycle
    logic [CW-1:0] pos_reg;      // entry index of current read data
    logic [AW-1:0] wr_pos_reg;   // gap position while shifting
    logic [31:0] wait_reg;

    logic          ram_we;
    logic [AW-1:0] ram_wa;
    pjst_pkg::entry_t ram_wd;
    logic [AW-1:0] ram_ra;
    logic [pjst_pkg::ENTRY_W-1:0] ram_rq;
    pjst_pkg::entry_t rd_e;

    logic        res_ok_reg, res_fin_reg;
    logic [15:0] res_nid_reg, res_dh_reg, res_did_reg;

    assign rd_e = pjst_pkg::entry_t'(ram_rq);

    pjst_ram #(.WIDTH(pjst_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (ram_ra),
        .rd_data (ram_rq)
    );

    // per-entry tests on the read data
    logic [31:0] due_t;
    logic        is_due;
    logic [31:0] lim;
    assign due_t  = rd_e.stamp + rd_e.period;
    assign is_due = (rd_e.period == 32'd0) || (due_t < now_reg);
    assign lim    = now_reg + wait_reg;

    logic ack;
    assign ack     = !m_valid || m_ready;
    assign s_ready = (state_reg == ST_IDLE) && ack;

    // RAM address and write control
    always_comb begin
        ram_we = 1'b0;
        ram_wa = AW'(occ_reg);
        ram_wd = rd_e;
        ram_ra = AW'(rd_idx_reg);
        if (state_reg == ST_IDLE) begin
            ram_ra = '0;
            ram_wa = AW'(occ_reg);
            ram_wd.handle = s_job_handle;
            ram_wd.id     = idc_reg;
            ram_wd.period = s_period;
            ram_wd.runs   = s_run_count;
            ram_wd.stamp  = s_now;
            ram_we = s_valid && s_ready && (s_mode == pjst_pkg::MODE_SCHEDULE)
                     && (occ_reg < DEPTH_C);
        end else if (state_reg == ST_SCAN && rd_live_reg && mode_reg == pjst_pkg::MODE_SERVICE
                     && is_due && rd_e.period != 32'd0 && !(rd_e.runs[15] == 1'b0
                     && rd_e.runs < 16'd2)) begin
            // update a staying due entry in place
            ram_we = 1'b1;
            ram_wa = AW'(pos_reg);
            ram_wd.stamp = now_reg;
            if (!rd_e.runs[15]) begin
                ram_wd.runs = rd_e.runs - 16'd1;
            end
        end else if (state_reg == ST_SHIFT && rd_live_reg) begin
            ram_we = 1'b1;
            ram_wa = wr_pos_reg;
        end
        // restart the read at entry 0 for the wait estimate scan
        if (state_reg == ST_SCAN && !rd_live_reg) begin
            ram_ra = '0;
        end
    end

    // sequencer, table state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            idc_reg     <= pjst_pkg::ID_FIRST;
            m_valid     <= 1'b0;
            rd_live_reg <= 1'b0;
        end else begin
            if (m_valid && m_ready && state_reg != ST_DONE) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        mode_reg    <= s_mode;
                        now_reg     <= s_now;
                        target_reg  <= s_target_id;
                        wait_reg    <= MAX_WAIT_W;
                        res_dh_reg  <= '0;
                        res_did_reg <= '0;
                        res_fin_reg <= 1'b0;
                        pos_reg     <= '0;
                        if (s_mode == pjst_pkg::MODE_SCHEDULE) begin
                            rd_idx_reg <= '0;
                            if (occ_reg < DEPTH_C) begin
                                occ_reg     <= occ_reg + CW'(1);
                                res_ok_reg  <= 1'b1;
                                res_nid_reg <= idc_reg;
                                idc_reg <= (idc_reg == pjst_pkg::ID_LAST) ?
                                           pjst_pkg::ID_FIRST : idc_reg + 16'd1;
                            end else begin
                                res_ok_reg  <= 1'b0;
                                res_nid_reg <= '0;
                            end
                            state_reg <= ST_DONE;
                        end else begin
                            res_ok_reg  <= 1'b0;
                            res_nid_reg <= '0;
                            if ((s_mode == pjst_pkg::MODE_REMOVE ||
                                 s_mode == pjst_pkg::MODE_SERVICE) &&
                                occ_reg != '0) begin
                                rd_idx_reg  <= CW'(1);
                                rd_live_reg <= 1'b1;
                                state_reg   <= ST_SCAN;
                            end else begin
                                rd_idx_reg <= '0;
                                state_reg  <= ST_DONE;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (!rd_live_reg) begin
                        if (mode_reg == pjst_pkg::MODE_SERVICE) begin
                            // nothing due: rescan for the wait estimate
                            rd_idx_reg  <= CW'(1);
                            pos_reg     <= '0;
                            rd_live_reg <= 1'b1;
                            state_reg   <= ST_WAIT_SCAN;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        // examine entry pos_reg, read ahead the next one
                        pos_reg     <= rd_idx_reg;
                        rd_idx_reg  <= rd_idx_reg + CW'(1);
                        rd_live_reg <= (rd_idx_reg < occ_reg);
                        if ((mode_reg == pjst_pkg::MODE_REMOVE &&
                             rd_e.id == target_reg) ||
                            (mode_reg == pjst_pkg::MODE_SERVICE && is_due)) begin
                            res_ok_reg <= 1'b1;
                            if (mode_reg == pjst_pkg::MODE_SERVICE) begin
                                res_dh_reg  <= rd_e.handle;
                                res_did_reg <= rd_e.id;
                            end
                            if (mode_reg == pjst_pkg::MODE_REMOVE || rd_e.period == 32'd0 ||
                                (!rd_e.runs[15] && rd_e.runs < 16'd2)) begin
                                // drop the entry: move later ones down by one
                                res_fin_reg <= (mode_reg == pjst_pkg::MODE_SERVICE);
                                wr_pos_reg  <= AW'(pos_reg);
                                occ_reg     <= occ_reg - CW'(1);
                                state_reg   <= ST_SHIFT;
                            end else begin
                                state_reg <= ST_DONE;
                            end
                        end
                    end
                end
                ST_SHIFT: begin
                    // read data is entry wr_pos+1 once live; the read of the
                    // next entry was already issued by the scan
                    rd_idx_reg  <= rd_idx_reg + CW'(1);
                    rd_live_reg <= (rd_idx_reg < occ_reg + CW'(1));
                    if (rd_live_reg) begin
                        wr_pos_reg <= wr_pos_reg + AW'(1);
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_WAIT_SCAN: begin
                    rd_idx_reg  <= rd_idx_reg + CW'(1);
                    rd_live_reg <= (rd_idx_reg < occ_reg);
                    if (!rd_live_reg) begin
                        state_reg <= ST_DONE;
                    end else if (rd_e.period == 32'd0) begin
                        wait_reg  <= 32'd1;
                        state_reg <= ST_DONE;
                    end else if (due_t < lim) begin
                        if (due_t <= now_reg) begin
                            wait_reg  <= 32'd1;
                            state_reg <= ST_DONE;
                        end else begin
                            wait_reg <= due_t - now_reg;
                        end
                    end
                end
                ST_DONE: begin
                    rd_live_reg <= 1'b0;
                    if (ack) begin
                        m_valid        <= 1'b1;
                        m_op_ok        <= res_ok_reg;
                        m_new_id       <= res_nid_reg;
                        m_due_handle   <= res_dh_reg;
                        m_due_id       <= res_did_reg;
                        m_due_final    <= res_fin_reg;
                        m_next_wait    <= (mode_reg == pjst_pkg::MODE_SERVICE && !res_ok_reg)
                                          ? wait_reg[6:0] : 7'd0;
                        m_entries_left <= 5'(occ_reg);
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/pjst_ram.sv =====
// ----------------------------------------------------------------------------
// pjst_ram: generic single-port-write, single-port-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module pjst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/pjst_checker.sv =====
// ----------------------------------------------------------------------------
// pjst_checker: port-level checks of the periodic job scheduler table
// Watches handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module pjst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_op_ok,
    input logic [15:0] m_new_id,
    input logic        m_due_final,
    input logic [6:0]  m_next_wait
);

    // hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // take no command while a result is stalled
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("command taken while result stalled");

    // drop ready right after a command beat is taken
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second command taken while one is in work");

    // a successful op reports no wait
    a_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_op_ok |-> m_next_wait == 7'd0)
        else $error("wait reported with successful op");

    // a final flag comes only with success and no new id
    a_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_due_final |-> m_op_ok && m_new_id == 16'd0)
        else $error("final flag without served job");

endmodule

bind periodic_job_scheduler_table pjst_checker u_pjst_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_op_ok     (m_op_ok),
    .m_new_id    (m_new_id),
    .m_due_final (m_due_final),
    .m_next_wait (m_next_wait)
);
